### sv/hsl2rgb_pkg.sv
// shared types and constants for the hsl to rgb converter
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  // default number of fraction bits of hue, saturation and lightness
  localparam int unsigned FRAC_BITS_DEF = 16;

  // pipeline depth from accepted input word to output register
  localparam int unsigned STAGES = 8;

  // one input word
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
  } hsl_t;

  // one output word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // piece of the hue ramp
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

endpackage

### sv/hsl2rgb_pq.sv
// q and p levels from saturation and lightness, stages one to five
`timescale 1ns / 1ps

module hsl2rgb_pq import hsl2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [15:0]          sat_i,
  input  logic [15:0]          lum_i,
  output logic [FRAC_BITS-1:0] d_o,
  output logic [FRAC_BITS-1:0] p_o,
  output logic [FRAC_BITS-1:0] q_o,
  output logic [FRAC_BITS-1:0] l_o,
  output logic                 grey_o
);

  localparam int unsigned W = FRAC_BITS;
  localparam logic [W:0] M_C  = (W+1)'((1 << W) - 1);
  localparam logic [W:0] M2_C = (W+1)'(((1 << W) - 1) * 2);

  // stage 1 signals
  logic [W+15:0] s_ext, l_ext;
  logic [W-1:0]  s_c, l_c;
  logic          lt;
  logic [W-1:0]  ma;
  logic [W:0]    mb;
  logic [2*W:0]  prod_d, prod_q;
  logic          lt1_q, grey1_q;
  logic [W-1:0]  l1_q;

  // stage 2 signals
  logic [2*W:0]   lm, q2_sum;
  logic [2*W-1:0] q2_q;
  logic           grey2_q;
  logic [W-1:0]   l2_q;

  // stage 3 signals
  logic [W-1:0] qa, qb;
  logic [W:0]   qs;
  logic [1:0]   qc;
  logic [W-1:0] q3_d, q3_q, l3_q;
  logic         grey3_q;

  // stage 4 signals
  logic [W:0]   p_wide;
  logic [W-1:0] p4_d, d4_d;
  logic [W-1:0] p4_q, q4_q, d4_q, l4_q;
  logic         grey4_q;

  // stage 5 signals
  logic [W-1:0] p5_q, q5_q, l5_q;
  logic         grey5_q;

  // stage 1: clamp to full scale and form the q numerator product
  always_comb begin
    s_ext = {{W{1'b0}}, sat_i};
    l_ext = {{W{1'b0}}, lum_i};
    s_c   = (s_ext > (W+16)'(M_C)) ? M_C[W-1:0] : s_ext[W-1:0];
    l_c   = (l_ext > (W+16)'(M_C)) ? M_C[W-1:0] : l_ext[W-1:0];
    lt    = ({l_c, 1'b0} < M_C);
    if (lt) begin
      ma = l_c;
      mb = M_C + {1'b0, s_c};
    end else begin
      ma = s_c;
      mb = M_C - {1'b0, l_c};
    end
    prod_d = (2*W+1)'(ma) * (2*W+1)'(mb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      lt1_q   <= lt;
      l1_q    <= l_c;
      grey1_q <= (s_c == '0);
    end
  end

  // stage 2: add l times full scale on the upper half
  always_comb begin
    lm     = {1'b0, l1_q, {W{1'b0}}} - (2*W+1)'(l1_q);
    q2_sum = prod_q + (lt1_q ? '0 : lm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q2_q    <= q2_sum[2*W-1:0];
      l2_q    <= l1_q;
      grey2_q <= grey1_q;
    end
  end

  // stage 3: divide by 2^W-1 as high plus low part with a small correction
  always_comb begin
    qa = q2_q[2*W-1:W];
    qb = q2_q[W-1:0];
    qs = {1'b0, qa} + {1'b0, qb};
    if (qs >= M2_C) begin
      qc = 2'd2;
    end else if (qs >= M_C) begin
      qc = 2'd1;
    end else begin
      qc = 2'd0;
    end
    q3_d = qa + W'(qc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q3_q    <= q3_d;
      l3_q    <= l2_q;
      grey3_q <= grey2_q;
    end
  end

  // stage 4: p = 2l - q and the ramp height q - p
  always_comb begin
    p_wide = {l3_q, 1'b0} - {1'b0, q3_q};
    p4_d   = p_wide[W-1:0];
    d4_d   = q3_q - p4_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p4_q    <= p4_d;
      q4_q    <= q3_q;
      d4_q    <= d4_d;
      l4_q    <= l3_q;
      grey4_q <= grey3_q;
    end
  end

  // stage 5: levels held alongside the ramp products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p5_q    <= p4_q;
      q5_q    <= q4_q;
      l5_q    <= l4_q;
      grey5_q <= grey4_q;
    end
  end

  assign d_o    = d4_q;
  assign p_o    = p5_q;
  assign q_o    = q5_q;
  assign l_o    = l5_q;
  assign grey_o = grey5_q;

endmodule

### sv/hsl2rgb_ramp.sv
// piecewise hue ramp for one channel, stages one to six
`timescale 1ns / 1ps

module hsl2rgb_ramp import hsl2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned THIRD     = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [15:0]          hue_i,
  input  logic [FRAC_BITS-1:0] d_i,
  input  logic [FRAC_BITS-1:0] p_i,
  input  logic [FRAC_BITS-1:0] q_i,
  input  logic [FRAC_BITS-1:0] l_i,
  input  logic                 grey_i,
  output logic [FRAC_BITS-1:0] x_o
);

  localparam int unsigned W = FRAC_BITS;
  localparam logic [W+2:0] H_C    = (W+3)'(1) << W;
  localparam logic [W+2:0] H2_C   = (W+3)'(1) << (W + 1);
  localparam logic [W+2:0] H3_C   = H_C + H2_C;
  localparam logic [W+2:0] OFS_C  = (W+3)'(THIRD << W);

  // stage 1 signals
  logic [W+15:0] h_ext;
  logic [W+2:0]  h_w, t_sum, t_wrap;
  logic [W+1:0]  t3_q;

  // stage 2 signals
  logic [W+2:0] tw, fd;
  seg_e         seg2_d, seg2_q, seg3_q, seg4_q, seg5_q;
  logic [W:0]   f2_d, f2_q, f3_q, f4_q;

  // stage 5 and 6 signals
  logic [2*W:0] m5_d, m5_q;
  logic [W-1:0] x6_d, x6_q;

  // stage 1: position in units of a third of the fraction step, wrapped to one turn
  always_comb begin
    h_ext  = {{W{1'b0}}, hue_i};
    h_w    = (W+3)'(h_ext[W-1:0]);
    t_sum  = (h_w << 1) + h_w + OFS_C;
    t_wrap = (t_sum >= H3_C) ? (t_sum - H3_C) : t_sum;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3_q <= t_wrap[W+1:0];
    end
  end

  // stage 2: pick the ramp piece and its slope factor
  always_comb begin
    tw   = {t3_q, 1'b0};
    fd   = (H2_C - {1'b0, t3_q}) << 1;
    f2_d = '0;
    if (tw < H_C) begin
      seg2_d = SEG_RISE;
      f2_d   = tw[W:0];
    end else if (tw < H3_C) begin
      seg2_d = SEG_HIGH;
    end else if ({1'b0, t3_q} < H2_C) begin
      seg2_d = SEG_FALL;
      f2_d   = fd[W:0];
    end else begin
      seg2_d = SEG_LOW;
    end
  end

  // stages 2 to 4: hold the piece until the height arrives
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg2_q <= seg2_d;
      f2_q   <= f2_d;
      seg3_q <= seg2_q;
      f3_q   <= f2_q;
      seg4_q <= seg3_q;
      f4_q   <= f3_q;
    end
  end

  // stage 5: height times slope factor
  assign m5_d = (2*W+1)'(d_i) * (2*W+1)'(f4_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m5_q   <= m5_d;
      seg5_q <= seg4_q;
    end
  end

  // stage 6: channel level
  always_comb begin
    if (grey_i) begin
      x6_d = l_i;
    end else begin
      case (seg5_q)
        SEG_RISE, SEG_FALL: x6_d = p_i + m5_q[2*W-1:W];
        SEG_HIGH:           x6_d = q_i;
        default:            x6_d = p_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x6_q <= x6_d;
    end
  end

  assign x_o = x6_q;

endmodule

### sv/hsl2rgb_byte.sv
// scale a channel level by 255.999 and truncate, stages seven and eight
`timescale 1ns / 1ps

module hsl2rgb_byte import hsl2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] x_i,
  output logic [7:0]           byte_o
);

  localparam int unsigned W = FRAC_BITS;
  localparam logic [W:0] M_C  = (W+1)'((1 << W) - 1);
  localparam logic [W:0] M2_C = (W+1)'(((1 << W) - 1) * 2);

  logic [W+7:0]  xs;
  logic [7:0]    ua;
  logic [W-1:0]  ub;
  logic [W:0]    us, r_wide;
  logic [1:0]    uc;
  logic [8:0]    u7_q;
  logic [W-1:0]  r7_q, x7_q;
  logic [W+9:0]  lhs, rhs;
  logic [8:0]    v;
  logic [7:0]    byte8_q;

  // stage 7: u = floor(256x / (2^W-1)) and its remainder
  always_comb begin
    xs = {x_i, 8'b0};
    ua = xs[W+7:W];
    ub = xs[W-1:0];
    us = (W+1)'(ua) + {1'b0, ub};
    if (us >= M2_C) begin
      uc     = 2'd2;
      r_wide = us - M2_C;
    end else if (us >= M_C) begin
      uc     = 2'd1;
      r_wide = us - M_C;
    end else begin
      uc     = 2'd0;
      r_wide = us;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u7_q <= 9'(ua) + 9'(uc);
      r7_q <= r_wide[W-1:0];
      x7_q <= x_i;
    end
  end

  // stage 8: drop one when the 0.001 shortfall crosses an integer
  always_comb begin
    lhs = (W+10)'(r7_q) * (W+10)'(1000);
    rhs = (W+10)'(x7_q);
    v   = (lhs >= rhs) ? u7_q : (u7_q - 9'd1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte8_q <= v[7:0];
    end
  end

  assign byte_o = byte8_q;

endmodule

### sv/hsl_to_rgb.sv
// hsl to rgb converter: an accepted word is output valid once it reaches the last stage register
// throughput one word per cycle; the 8 stages advance together unless a finished word waits
// a stalled output freezes every stage, so nothing is lost or repeated
// reset clears the stage valid bits only; data registers are not reset
`timescale 1ns / 1ps

module hsl_to_rgb import hsl2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  hsl_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rgb_t out_data_o
);

  localparam int unsigned W = FRAC_BITS;

  logic               adv;
  logic [STAGES-1:0]  valid_q, valid_d;
  logic [W-1:0]       d4, p5, q5, l5;
  logic               grey5;
  logic [W-1:0]       xr, xg, xb;
  logic [7:0]         br, bg, bb;

  // whole pipe moves unless a finished word is held at the output
  assign adv        = !valid_q[STAGES-1] || out_ready_i;
  assign in_ready_o = adv;

  // valid bits travel with the data
  always_comb begin
    valid_d = valid_q;
    if (adv) begin
      valid_d = {valid_q[STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // q, p and height
  hsl2rgb_pq #(.FRAC_BITS(FRAC_BITS)) u_pq (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sat_i  (in_data_i.saturation),
    .lum_i  (in_data_i.lightness),
    .d_o    (d4),
    .p_o    (p5),
    .q_o    (q5),
    .l_o    (l5),
    .grey_o (grey5)
  );

  // red at hue plus a third, green at hue, blue at hue minus a third
  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS), .THIRD(1)) u_ramp_r (
    .clk_i (clk_i), .en_i (adv), .hue_i (in_data_i.hue), .d_i (d4),
    .p_i (p5), .q_i (q5), .l_i (l5), .grey_i (grey5), .x_o (xr)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS), .THIRD(0)) u_ramp_g (
    .clk_i (clk_i), .en_i (adv), .hue_i (in_data_i.hue), .d_i (d4),
    .p_i (p5), .q_i (q5), .l_i (l5), .grey_i (grey5), .x_o (xg)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS), .THIRD(2)) u_ramp_b (
    .clk_i (clk_i), .en_i (adv), .hue_i (in_data_i.hue), .d_i (d4),
    .p_i (p5), .q_i (q5), .l_i (l5), .grey_i (grey5), .x_o (xb)
  );

  // byte scaling per channel
  hsl2rgb_byte #(.FRAC_BITS(FRAC_BITS)) u_byte_r (
    .clk_i (clk_i), .en_i (adv), .x_i (xr), .byte_o (br)
  );

  hsl2rgb_byte #(.FRAC_BITS(FRAC_BITS)) u_byte_g (
    .clk_i (clk_i), .en_i (adv), .x_i (xg), .byte_o (bg)
  );

  hsl2rgb_byte #(.FRAC_BITS(FRAC_BITS)) u_byte_b (
    .clk_i (clk_i), .en_i (adv), .x_i (xb), .byte_o (bb)
  );

  assign out_valid_o = valid_q[STAGES-1];
  assign out_data_o  = '{red: br, green: bg, blue: bb};

  // an accepted word always lands in the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted word missing from first stage");

  // a held output freezes the stage valid bits
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(valid_q))
    else $error("pipeline moved while output stalled");

  // levels keep p <= l <= q for colored words
  a_level_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] && !grey5 |-> (p5 <= l5) && (l5 <= q5))
    else $error("p, l, q out of order");

endmodule

### tb/tb_top.sv
// self-checking testbench for the hsl to rgb converter: paced driver, monitor, scoreboard
`timescale 1ns / 1ps

module tb_top;
  import hsl2rgb_pkg::*;

  // pacing of the two channels, taken from the word being offered
  typedef enum int {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL_RATE
  } pace_e;

  // one pending input word with its pacing and an optional drain before it
  typedef struct {
    hsl_t  word;
    pace_e pace;
    bit    drain_first;
  } stim_word_t;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned SINK_HOLD_CYCLES = 80;
  localparam int unsigned SINK_HOLD_AFTER = 120;
  localparam int unsigned RANDOM_PER_PACE = 145;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  hsl_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rgb_t out_data_o;

  stim_word_t  pending_words[$];
  rgb_t        rgb_expected[$];
  pace_e       pace_now = PACE_SLOW_SINK;
  int unsigned words_sent = 0;
  int unsigned colors_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sink_hold_left = 0;
  bit          sink_hold_done = 1'b0;

  hsl_to_rgb uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // hue ramp value at a position in units of one third of a turn step
  function automatic longint unsigned ramp_level(longint unsigned p, longint unsigned q,
                                                 longint unsigned pos, longint unsigned turn);
    seg_e piece;
    longint unsigned rise;
    rise = q - p;
    if (2 * pos < turn) piece = SEG_RISE;
    else if (2 * pos < 3 * turn) piece = SEG_HIGH;
    else if (pos < 2 * turn) piece = SEG_FALL;
    else piece = SEG_LOW;
    case (piece)
      SEG_RISE: return p + (rise * 2 * pos) / turn;
      SEG_HIGH: return q;
      SEG_FALL: return p + (rise * 2 * (2 * turn - pos)) / turn;
      default:  return p;
    endcase
  endfunction

  // scale a channel fraction to a byte by 255.999, truncating
  function automatic logic [7:0] channel_byte(longint unsigned x, longint unsigned full);
    longint unsigned v;
    v = (x * 64'd255999) / (64'd1000 * full);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // expected color for one hsl word
  function automatic rgb_t rgb_of_hsl(hsl_t w);
    longint unsigned turn, full, h, s, l, q2, q, p, h3, span;
    rgb_t c;
    turn = 64'd1 << FRAC_BITS_DEF;
    full = turn - 1;
    h = w.hue & (turn - 1);
    s = w.saturation;
    l = w.lightness;
    if (s > full) s = full;
    if (l > full) l = full;
    if (s == 0) begin
      c.red   = channel_byte(l, full);
      c.green = channel_byte(l, full);
      c.blue  = channel_byte(l, full);
    end else begin
      // q from lightness and saturation, split at lightness one half
      if (2 * l < full) q2 = l * (full + s);
      else q2 = l * full + s * full - l * s;
      q = q2 / full;
      p = 2 * l - q;
      span = 3 * turn;
      h3 = 3 * h;
      c.red   = channel_byte(ramp_level(p, q, (h3 + turn) % span, turn), full);
      c.green = channel_byte(ramp_level(p, q, h3 % span, turn), full);
      c.blue  = channel_byte(ramp_level(p, q, (h3 + 2 * turn) % span, turn), full);
    end
    return c;
  endfunction

  // random field value leaning toward the extremes and the midpoint
  function automatic logic [15:0] pick_field();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF + 16'($urandom_range(2));
      3: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [15:0] h, input logic [15:0] s, input logic [15:0] l,
                          input pace_e pace, input bit drain_first);
    stim_word_t item;
    item.word.hue = h;
    item.word.saturation = s;
    item.word.lightness = l;
    item.pace = pace;
    item.drain_first = drain_first;
    pending_words.push_back(item);
  endtask

  // driver: offers pending words, records the expected color on each accept
  always @(posedge clk_i) begin
    logic next_valid;
    stim_word_t head;
    int unsigned gap_pct;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        rgb_expected.push_back(rgb_of_hsl(in_data_i));
        words_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_words.size() != 0) begin
        head = pending_words[0];
        gap_pct = (head.pace == PACE_SLOW_SINK) ? 12 : (head.pace == PACE_SLOW_SOURCE) ? 53 : 0;
        if (!(head.drain_first && rgb_expected.size() != 0) &&
            $urandom_range(99) >= gap_pct) begin
          void'(pending_words.pop_front());
          in_data_i <= head.word;
          pace_now = head.pace;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // monitor: compares each output word with the oldest expectation, paces ready
  always @(posedge clk_i) begin
    rgb_t want;
    logic next_ready;
    int unsigned stall_pct;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (rgb_expected.size() == 0) begin
          $error("output word %h with no expectation waiting", out_data_o);
          mismatch_count++;
        end else begin
          want = rgb_expected.pop_front();
          colors_checked++;
          if (out_data_o.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, out_data_o.red);
            mismatch_count++;
          end
          if (out_data_o.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, out_data_o.green);
            mismatch_count++;
          end
          if (out_data_o.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, out_data_o.blue);
            mismatch_count++;
          end
        end
      end
      // paced random stalls, plus one long stall so the pipeline fills and back-pressures the input
      stall_pct = (pace_now == PACE_SLOW_SINK) ? 53 : (pace_now == PACE_SLOW_SOURCE) ? 12 : 0;
      if (sink_hold_left != 0) begin
        sink_hold_left--;
        next_ready = 1'b0;
      end else if (!sink_hold_done && words_sent >= SINK_HOLD_AFTER) begin
        sink_hold_done = 1'b1;
        sink_hold_left = SINK_HOLD_CYCLES - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = ($urandom_range(99) >= stall_pct);
      end
      out_ready_i <= next_ready;
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [15:0] breakpoints[12];
    rst_ni = 1'b0;

    // grey, field extremes and the lightness one-half boundary
    add_word(16'h1234, 16'h0000, 16'h0000, PACE_SLOW_SINK, 1'b0);
    add_word(16'hABCD, 16'h0000, 16'hFFFF, PACE_SLOW_SINK, 1'b0);
    add_word(16'h5555, 16'h0000, 16'h8000, PACE_SLOW_SINK, 1'b0);
    add_word(16'h0000, 16'hFFFF, 16'h0000, PACE_SLOW_SINK, 1'b0);
    add_word(16'hFFFF, 16'hFFFF, 16'hFFFF, PACE_SLOW_SINK, 1'b0);
    add_word(16'hFFFF, 16'h0001, 16'h0001, PACE_SLOW_SINK, 1'b0);
    add_word(16'h4000, 16'h8000, 16'h7FFF, PACE_SLOW_SINK, 1'b0);
    add_word(16'h4000, 16'h8000, 16'h8000, PACE_SLOW_SINK, 1'b0);
    add_word(16'h0000, 16'hFFFF, 16'h7FFF, PACE_SLOW_SINK, 1'b0);
    // hue on both sides of the sixth, third, half, two-thirds and five-sixths points, and the wrap
    breakpoints = '{16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
                    16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'd65535};
    foreach (breakpoints[i]) add_word(breakpoints[i], 16'hFFFF, 16'h8000, PACE_SLOW_SINK, 1'b0);

    // random words in three pacing phases; the sender drains at each phase change and on rare random words
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < RANDOM_PER_PACE; n++) begin
        add_word(pick_field(), pick_field(), pick_field(), pace_e'(ph),
                 (n == 0 && ph != 0) || ($urandom_range(99) == 0));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i || rgb_expected.size() != 0)
      @(posedge clk_i);
    repeat (STAGES + 4) @(posedge clk_i);

    if (rgb_expected.size() != 0) begin
      $error("%0d expected colors never arrived", rgb_expected.size());
      mismatch_count++;
    end
    $display("sent %0d hsl words, compared %0d rgb words channel by channel",
             words_sent, colors_checked);
    $display("covered grey, hue breakpoints, slow sink, slow source, full rate and back-pressure");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/hsl2rgb_pkg.sv
sv/hsl2rgb_pq.sv
sv/hsl2rgb_ramp.sv
sv/hsl2rgb_byte.sv
sv/hsl_to_rgb.sv
tb/tb_top.sv
